[sv/etfi_pkg.sv]
// ----------------------------------------------------------------------------
// etfi_pkg
// Shared types and fixed-point constants for the escape-time fractal iterator.
// ----------------------------------------------------------------------------
package etfi_pkg;

    // Q4.28 number format and result count width
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;

    // Width of the update accumulator: product difference plus shifted constant
    localparam int ACC_W = ((31 + FRAC_BITS > 63) ? (31 + FRAC_BITS) : 63) + 2;

    // The escape limit of 4 exists only while it fits a 64-bit squared sum
    localparam bit          REACHABLE  = (2 * FRAC_BITS + 2) <= 63;
    localparam logic [63:0] ESC_LIMIT  = REACHABLE ? (64'd1 << (2 * FRAC_BITS + 2)) : 64'd0;
    localparam logic [15:0] COUNT_MASK = 16'((64'd1 << COUNT_BITS) - 64'd1);

    // Job queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REG_MODE     = 2'd0,
        REG_MAX_ITER = 2'd1,
        REG_C_RE     = 2'd2,
        REG_C_IM     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic               mode;
        logic [15:0]        max_iter;
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
    } cfg_t;

    // Starting z and the constant c of one point
    typedef struct packed {
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
    } job_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_status_t;

    // Clamp an accumulator value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[ACC_W-1:31];
        all_zeros = ~|v[ACC_W-1:31];
        if (all_ones || all_zeros)
        begin
            return v[31:0];
        end
        return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage

[sv/etfi_front.sv]
// ----------------------------------------------------------------------------
// etfi_front
// Accepts points and sorts them into a starting z and constant c by mode.
// ----------------------------------------------------------------------------
module etfi_front (
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [31:0]       point_re,
    input  logic signed [31:0]       point_im,
    input  etfi_pkg::cfg_t           cfg,
    input  etfi_pkg::q_status_t      q_status,
    output logic                     push,
    output etfi_pkg::job_t           push_job
);
    import etfi_pkg::*;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        if (cfg.mode)
        begin
            // Julia: z starts at the point, c from configuration
            push_job.zr = point_re;
            push_job.zi = point_im;
            push_job.cr = cfg.c_re;
            push_job.ci = cfg.c_im;
        end
        else
        begin
            // Mandelbrot: z starts at zero, c is the point
            push_job.zr = '0;
            push_job.zi = '0;
            push_job.cr = point_re;
            push_job.ci = point_im;
        end
    end

endmodule

[sv/etfi_queue.sv]
// ----------------------------------------------------------------------------
// etfi_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module etfi_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  etfi_pkg::job_t           push_job,
    input  logic                     pop,
    output etfi_pkg::job_t           head_job,
    output etfi_pkg::q_status_t      q_status
);
    import etfi_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job          = mem_reg[rd_ptr_reg];
    assign q_status.full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.nonempty = (count_reg != '0);

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
    else $error("queue fill level did not advance on push");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.nonempty)
    else $error("pop from an empty queue");
`endif

endmodule

[sv/etfi_back.sv]
// ----------------------------------------------------------------------------
// etfi_back
// Runs z = z*z + c on one job, a squaring state then an update state per escape check,
// and holds the escape count in an output register until it is taken.
// ----------------------------------------------------------------------------
module etfi_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [15:0]              max_iter,
    input  etfi_pkg::q_status_t      q_status,
    input  etfi_pkg::job_t           head_job,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [15:0]              escape_count
);
    import etfi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [15:0]        k_reg;
    logic [15:0]        k_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [15:0]        out_count_reg;

    logic signed [31:0] zr_reg;
    logic signed [31:0] zi_reg;
    logic signed [31:0] cr_reg;
    logic signed [31:0] ci_reg;
    logic signed [63:0] rr_reg;
    logic signed [63:0] ii_reg;
    logic signed [63:0] ri_reg;

    logic [63:0]          mag;
    logic                 escape;
    logic                 done_esc;
    logic                 done_none;
    logic                 upd_done;
    logic                 slot_free;
    logic                 load_out;
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    logic signed [31:0]   zr_new;
    logic signed [31:0]   zi_new;

    // Escape test on the exact squared modulus
    assign mag       = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign escape    = REACHABLE && (mag > ESC_LIMIT);
    assign done_esc  = escape && (k_reg <= max_iter);
    assign done_none = !done_esc && (k_reg >= max_iter);
    assign upd_done  = done_esc || done_none;

    // Fold c in before the floor shift; the result is the same
    assign acc_re = ACC_W'(rr_reg) - ACC_W'(ii_reg) + (ACC_W'(cr_reg) <<< FRAC_BITS);
    assign acc_im = ACC_W'(ri_reg) + (ACC_W'(ci_reg) <<< (FRAC_BITS - 1));
    assign zr_new = sat32(acc_re >>> FRAC_BITS);
    assign zi_new = sat32(acc_im >>> (FRAC_BITS - 1));

    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == S_IDLE) && q_status.nonempty;
    assign load_out  = (state_reg == S_UPD) && upd_done && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (q_status.nonempty)
                begin
                    k_next     = 16'd1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!upd_done)
                begin
                    k_next     = k_reg + 16'd1;
                    state_next = S_MUL;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            zr_reg <= head_job.zr;
            zi_reg <= head_job.zi;
            cr_reg <= head_job.cr;
            ci_reg <= head_job.ci;
        end
        else if ((state_reg == S_UPD) && !upd_done)
        begin
            zr_reg <= zr_new;
            zi_reg <= zi_new;
        end

        if (state_reg == S_MUL)
        begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end

        if (load_out)
        begin
            out_count_reg <= done_esc ? (k_reg & COUNT_MASK) : 16'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign escape_count = out_count_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_UPD))
    else $error("products not followed by an update");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && !upd_done) |=>
            (state_reg == S_MUL && k_reg == $past(k_reg) + 16'd1))
    else $error("check index did not advance by one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && q_status.nonempty) |=>
            (state_reg == S_MUL && k_reg == 16'd1))
    else $error("new job did not start at the first check");
`endif

endmodule

[sv/escape_time_fractal_iterator.sv]
// Flow: with the back idle, an accepted point is queued, popped in the idle state, then run
// through a squaring state and an update state per escape check, at least one check even at
// max_iter 0; the back pops the next point only after it is back in idle, and a stalled
// output holds the back until the count is taken.
// Reset: mode Mandelbrot, max_iter 100, Julia constant zero, queue and output empty.
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Escape-time iterator for Mandelbrot and Julia sets in signed Q4.28, with an
// APB-style register port, a front that sorts points and a back that iterates.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] point_re,
    input  logic signed [31:0] point_im,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        escape_count
);
    import etfi_pkg::*;

    cfg_t      cfg_reg;
    reg_idx_t  reg_idx;
    logic      wr_en;
    q_status_t q_status;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= 1'b0;
            cfg_reg.max_iter <= 16'd100;
            cfg_reg.c_re     <= '0;
            cfg_reg.c_im     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MODE:     cfg_reg.mode     <= pwdata[0];
                REG_MAX_ITER: cfg_reg.max_iter <= pwdata[15:0];
                REG_C_RE:     cfg_reg.c_re     <= pwdata;
                REG_C_IM:     cfg_reg.c_im     <= pwdata;
                default:      cfg_reg.mode     <= cfg_reg.mode;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:     prdata = {31'd0, cfg_reg.mode};
            REG_MAX_ITER: prdata = {16'd0, cfg_reg.max_iter};
            REG_C_RE:     prdata = cfg_reg.c_re;
            REG_C_IM:     prdata = cfg_reg.c_im;
            default:      prdata = '0;
        endcase
    end

    etfi_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .point_re (point_re),
        .point_im (point_im),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    etfi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    etfi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_iter     (cfg_reg.max_iter),
        .q_status     (q_status),
        .head_job     (head_job),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_count (escape_count)
    );

endmodule

[verif/escape_time_fractal_iterator_test.sv]
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_test
// Self-checking bench for the escape-time iterator: a table of corner points,
// then phases of random points under changing mode, limit and Julia constant.
// Every escape count is compared with a tabled value or a fixed-point predictor of the iteration.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_test;

    import etfi_pkg::*;

    localparam int QUIET_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [15:0]        count;
    } escape_rec_t;

    typedef struct {
        bit                 mode;
        logic [15:0]        iter;
        logic signed [31:0] re;
        logic signed [31:0] im;
        bit                 known;
        logic [15:0]        count;
    } probe_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        escape_count;

    // shadow of the register file
    bit                 cfg_mode;
    logic [15:0]        cfg_iter;
    logic signed [31:0] cfg_c_re;
    logic signed [31:0] cfg_c_im;

    escape_rec_t        pending_counts[$];
    escape_rec_t        oldest;
    int                 mismatches;
    int                 burst_left;
    int                 stall_left;
    int                 stall_pct;
    int                 stall_phase_left;
    int                 quiet_cycles;

    // corner points first, then the limit and mode extremes
    probe_t probes [0:21] = '{
        '{1'b0, 16'd100, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{1'b0, 16'd100, 32'h4000_0000, 32'h0000_0000, 1'b1, 16'd2},
        '{1'b0, 16'd100, 32'hC000_0000, 32'hC000_0000, 1'b1, 16'd2},
        '{1'b0, 16'd100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd2},
        '{1'b0, 16'd100, 32'h8000_0000, 32'h8000_0000, 1'b1, 16'd2},
        '{1'b0, 16'd100, 32'hE000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{1'b0, 16'd100, 32'h2000_0000, 32'h0000_0000, 1'b1, 16'd3},
        '{1'b0, 16'd100, 32'h0000_0000, 32'h4000_0000, 1'b1, 16'd2},
        '{1'b0, 16'd100, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 16'd0},
        '{1'b0, 16'd100, 32'hF000_0000, 32'h0800_0000, 1'b0, 16'd0},
        '{1'b0, 16'd100, 32'h0400_0000, 32'h0A00_0000, 1'b0, 16'd0},
        '{1'b1, 16'd100, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{1'b1, 16'd100, 32'h2000_0001, 32'h0000_0000, 1'b1, 16'd1},
        '{1'b1, 16'd100, 32'h1000_0000, 32'h1000_0000, 1'b1, 16'd3},
        '{1'b1, 16'd100, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'd1},
        '{1'b0, 16'd0,   32'h4000_0000, 32'h4000_0000, 1'b1, 16'd0},
        '{1'b0, 16'd0,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'd0},
        '{1'b0, 16'd1,   32'h4000_0000, 32'h0000_0000, 1'b1, 16'd0},
        '{1'b1, 16'd1,   32'h4000_0000, 32'h0000_0000, 1'b1, 16'd1},
        '{1'b1, 16'd1,   32'h1FFF_FFFF, 32'h0000_0000, 1'b1, 16'd0},
        '{1'b0, 16'd2,   32'h2000_0001, 32'h0000_0000, 1'b1, 16'd2},
        '{1'b0, 16'd2,   32'h2000_0000, 32'h0000_0000, 1'b1, 16'd0}
    };

    escape_time_fractal_iterator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_re     (point_re),
        .point_im     (point_im),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .escape_count (escape_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Iterate z = z*z + c and return the check index of escape, 0 if none
    function automatic logic [15:0] escape_count_of(input logic signed [31:0] pre,
                                                    input logic signed [31:0] pim);
        longint      zr;
        longint      zi;
        longint      cr;
        longint      ci;
        longint      rr;
        longint      ii;
        longint      ri;
        logic [63:0] mag;
        logic [63:0] bound;
        bit          reach;
        logic [15:0] count;
        reach = (2 * FRAC_BITS + 2) <= 63;
        bound = reach ? (64'd1 << (2 * FRAC_BITS + 2)) : 64'd0;
        count = '0;
        if (cfg_mode)
        begin
            zr = pre;
            zi = pim;
            cr = cfg_c_re;
            ci = cfg_c_im;
        end
        else
        begin
            zr = 0;
            zi = 0;
            cr = pre;
            ci = pim;
        end
        for (int k = 1; k <= cfg_iter; k++)
        begin
            rr  = zr * zr;
            ii  = zi * zi;
            ri  = zr * zi;
            // exact squared modulus against 4, both at 2*FRAC_BITS fraction bits
            mag = 64'(rr) + 64'(ii);
            if (reach && mag > bound)
            begin
                count = 16'(longint'(k) & ((longint'(1) << COUNT_BITS) - 1));
                break;
            end
            zr = clamp32(((rr - ii) >>> FRAC_BITS) + cr);
            zi = clamp32((ri >>> (FRAC_BITS - 1)) + ci);
        end
        return count;
    endfunction

    function automatic logic signed [31:0] rand_fixed(input longint lo, input longint hi);
        return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    endfunction

    function automatic logic signed [31:0] corner_value();
        case ($urandom_range(0, 7))
            0:       return 32'h4000_0000;
            1:       return 32'hC000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h2000_0000;
            5:       return 32'hE000_0000;
            6:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    task automatic pick_point(input bit wide, output logic signed [31:0] re,
                              output logic signed [31:0] im);
        int pick;
        pick = $urandom_range(0, 99);
        if (wide || pick < 15)
        begin
            re = rand_fixed(-64'sd1073741824, 64'sd1073741824);
            im = rand_fixed(-64'sd1073741824, 64'sd1073741824);
        end
        else if (pick < 85)
        begin
            // around the set, where the counts run long
            re = rand_fixed(-64'sd603979776, 64'sd201326592);
            im = rand_fixed(-64'sd335544320, 64'sd335544320);
        end
        else if (pick < 95)
        begin
            re = $urandom;
            im = $urandom;
        end
        else
        begin
            re = corner_value();
            im = corner_value();
        end
    endtask

    // Offer one point; record its expected count once the transaction completes
    task automatic push_point(input logic signed [31:0] re, input logic signed [31:0] im,
                              input bit known, input logic [15:0] typed);
        int          gap;
        escape_rec_t rec;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                point_re = $urandom;
                point_im = $urandom;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        point_re = re;
        point_im = im;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        rec.re    = re;
        rec.im    = im;
        rec.count = known ? typed : escape_count_of(re, im);
        pending_counts.push_back(rec);
    endtask

    // Drop valid and wait for every outstanding count
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_MODE:     cfg_mode = value[0];
            REG_MAX_ITER: cfg_iter = value[15:0];
            REG_C_RE:     cfg_c_re = value;
            REG_C_IM:     cfg_c_im = value;
            default:      ;
        endcase
    endtask

    task automatic configure(input bit mode, input logic [15:0] iter,
                             input logic signed [31:0] cre, input logic signed [31:0] cim,
                             input bit all);
        settle();
        if (all || mode != cfg_mode)
        begin
            write_reg(REG_MODE, {31'd0, mode});
        end
        if (all || iter != cfg_iter)
        begin
            write_reg(REG_MAX_ITER, {16'd0, iter});
        end
        if (all || cre != cfg_c_re)
        begin
            write_reg(REG_C_RE, cre);
        end
        if (all || cim != cfg_c_im)
        begin
            write_reg(REG_C_IM, cim);
        end
    endtask

    task automatic run_phase(input bit mode, input logic [15:0] iter,
                             input logic signed [31:0] cre, input logic signed [31:0] cim,
                             input int count, input bit wide, input bit origin);
        logic signed [31:0] re;
        logic signed [31:0] im;
        configure(mode, iter, cre, cim, 1'b1);
        // the origin never escapes: one full run to the limit
        if (origin)
        begin
            push_point(32'sd0, 32'sd0, 1'b0, 16'd0);
        end
        repeat (count)
        begin
            pick_point(wide, re, im);
            push_point(re, im, 1'b0, 16'd0);
        end
    endtask

    // Receiver: stall in short runs, with a density that drifts over time
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
            if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 6);
            end
        end
        if (stall_phase_left <= 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                2:       stall_pct = 40;
                default: stall_pct = 80;
            endcase
            stall_phase_left = $urandom_range(50, 400);
        end
        else
        begin
            stall_phase_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                $display("%0t: escape count %0d with no point outstanding", $time, escape_count);
                mismatches++;
            end
            else
            begin
                oldest = pending_counts.pop_front();
                if (escape_count !== oldest.count)
                begin
                    $display("%0t: point (%h, %h): expected count %0d, actual %0d",
                             $time, oldest.re, oldest.im, oldest.count, escape_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transaction on any port
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_valid         = 1'b0;
        point_re         = '0;
        point_im         = '0;
        out_stall        = 1'b0;
        cfg_mode         = 1'b0;
        cfg_iter         = 16'd100;
        cfg_c_re         = '0;
        cfg_c_im         = '0;
        mismatches       = 0;
        burst_left       = 0;
        stall_left       = 0;
        stall_pct        = 0;
        stall_phase_left = 0;
        quiet_cycles     = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (probes[i])
        begin
            if (probes[i].mode != cfg_mode || probes[i].iter != cfg_iter)
            begin
                configure(probes[i].mode, probes[i].iter, cfg_c_re, cfg_c_im, 1'b0);
            end
            push_point(probes[i].re, probes[i].im, probes[i].known, probes[i].count);
        end

        run_phase(1'b0, 16'd100, rand_fixed(-64'sd268435456, 64'sd268435456),
                  rand_fixed(-64'sd268435456, 64'sd268435456), 250, 1'b0, 1'b0);
        run_phase(1'b1, 16'd100, rand_fixed(-64'sd268435456, 64'sd268435456),
                  rand_fixed(-64'sd268435456, 64'sd268435456), 200, 1'b0, 1'b0);
        run_phase(1'b0, 16'($urandom_range(1, 30)), '0, '0, 150, 1'b0, 1'b0);
        run_phase(1'b1, 16'($urandom_range(1, 50)),
                  rand_fixed(-64'sd268435456, 64'sd268435456),
                  rand_fixed(-64'sd268435456, 64'sd268435456), 150, 1'b0, 1'b0);
        run_phase(1'b1, 16'd80, 32'h4000_0000, 32'hC000_0000, 60, 1'b0, 1'b0);
        run_phase(1'b0, 16'd0, 32'hC000_0000, 32'h4000_0000, 30, 1'b0, 1'b0);
        run_phase(1'b1, 16'd0, 32'h0000_0000, 32'h0000_0000, 30, 1'b0, 1'b0);
        // deepest limit: wide points mostly escape early, the origin runs it out
        run_phase(1'b0, 16'hFFFF, $urandom, $urandom, 12, 1'b1, 1'b1);
        run_phase(1'b1, 16'hFFFF, 32'h0000_0000, 32'h0000_0000, 12, 1'b1, 1'b0);
        run_phase(1'b0, 16'd1, $urandom, $urandom, 40, 1'b0, 1'b0);
        run_phase(1'b1, 16'($urandom_range(100, 400)), $urandom, $urandom, 80, 1'b0, 1'b0);
        run_phase(1'b0, 16'($urandom_range(2, 200)),
                  rand_fixed(-64'sd1073741824, 64'sd1073741824),
                  rand_fixed(-64'sd1073741824, 64'sd1073741824), 200, 1'b0, 1'b0);
        run_phase(1'b1, 16'd100, 32'h7FFF_FFFF, 32'h8000_0000, 40, 1'b0, 1'b0);
        run_phase(1'b0, 16'd100, 32'h0000_0000, 32'h0000_0000, 100, 1'b0, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
